// ===== rtl/ultrasonic_trigger_scheduler_stop_assert.svh =====
// ----------------------------------------------------------------------------
// Ultrasonic trigger scheduler assertion macros
// Shorthand for the clocked, reset-qualified assertions of the checker.
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_TRIGGER_SCHEDULER_STOP_ASSERT_SVH
`define ULTRASONIC_TRIGGER_SCHEDULER_STOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define UTS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define UTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/uts_pkg.sv =====
// ----------------------------------------------------------------------------
// Ultrasonic trigger scheduler package
// Shared codes, reset values and transaction types.
// ----------------------------------------------------------------------------
package uts_pkg;

   localparam logic [1:0] ACT_TICK         = 2'd0;
   localparam logic [1:0] ACT_SET_OVERRIDE = 2'd1;
   localparam logic [1:0] ACT_SET_REAR     = 2'd2;

   localparam logic [7:0] MODE_DRIVE = 8'd15;
   localparam logic [7:0] MODE_PARK  = 8'd30;

   localparam logic [31:0] FIRST_TRIGGER_MS = 32'd200;

   localparam logic [1:0] CSR_TRIGGER_GAP = 2'd0;
   localparam logic [1:0] CSR_BRAKE       = 2'd1;
   localparam logic [1:0] CSR_RELEASE     = 2'd2;

   localparam logic [15:0] GAP_RESET     = 16'd60;
   localparam logic [14:0] BRAKE_RESET   = 15'd300;
   localparam logic [14:0] RELEASE_RESET = 15'd400;

   typedef struct packed {
      logic [1:0]         action;
      logic               command_on;
      logic [31:0]        time_ms;
      logic [7:0]         mode_code;
      logic               front_busy;
      logic               rear_busy;
      logic               front_new;
      logic signed [15:0] front_distance;
      logic               rear_new;
      logic signed [15:0] rear_distance;
   } req_type;

   typedef struct packed {
      logic        fire_front;
      logic        fire_rear;
      logic        safety_stop;
      logic        rear_report_valid;
      logic        rear_report_timeout;
      logic [14:0] rear_report_mm;
      logic        command_ack;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  index;
      logic [15:0] data;
   } csr_type;

endpackage

// ===== rtl/uts_in_stage.sv =====
// ----------------------------------------------------------------------------
// Ultrasonic trigger scheduler input stage
// Register one request transaction and hand it on when the engine takes it.
// ----------------------------------------------------------------------------
module uts_in_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  uts_pkg::req_type in_data,
   output logic             out_valid,
   input  logic             out_take,
   output uts_pkg::req_type out_data
);
   import uts_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   req_type data_ff;

   // Free slot, or the held item leaves this cycle.
   assign in_ready = !valid_ff || out_take;
   assign valid_in = (in_valid && in_ready) || (valid_ff && !out_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid && in_ready) begin
         data_ff <= in_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== rtl/uts_engine.sv =====
// ----------------------------------------------------------------------------
// Ultrasonic trigger scheduler engine
// Hold the scheduler state and settings; work out one result per step.
// ----------------------------------------------------------------------------
module uts_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  uts_pkg::req_type req,
   input  logic             csr_we,
   input  uts_pkg::csr_type csr,
   output uts_pkg::rsp_type rsp
);
   import uts_pkg::*;

   logic        next_is_rear_ff, next_is_rear_in;
   logic [31:0] next_trigger_ff, next_trigger_in;
   logic        stop_request_ff, stop_request_in;
   logic        front_override_ff, front_override_in;
   logic        rear_enabled_ff, rear_enabled_in;

   logic [15:0] gap_ff;
   logic [14:0] brake_ff;
   logic [14:0] release_ff;

   logic [31:0] since_due;
   logic        mode_on;
   logic        rear_allowed;
   logic        trigger_now;
   logic        front_positive;
   logic        stop_set;

   assign since_due      = req.time_ms - next_trigger_ff;
   assign mode_on        = (req.mode_code == MODE_DRIVE) || (req.mode_code == MODE_PARK);
   assign rear_allowed   = rear_enabled_ff && (req.mode_code == MODE_PARK);
   assign trigger_now    = !since_due[31] && !req.front_busy && !req.rear_busy;
   assign front_positive = !req.front_distance[15] && (req.front_distance != 16'sd0);
   // Set test first, then release test on the updated request.
   assign stop_set       = stop_request_ff || (req.front_distance[14:0] <= brake_ff);

   always_comb begin
      next_is_rear_in   = next_is_rear_ff;
      next_trigger_in   = next_trigger_ff;
      stop_request_in   = stop_request_ff;
      front_override_in = front_override_ff;
      rear_enabled_in   = rear_enabled_ff;
      rsp               = '0;
      unique case (req.action)
         ACT_SET_OVERRIDE: begin
            front_override_in = req.command_on;
            rsp.command_ack   = req.command_on;
         end
         ACT_SET_REAR: begin
            rear_enabled_in = req.command_on;
            rsp.command_ack = req.command_on;
         end
         ACT_TICK: begin
            if (!mode_on) begin
               stop_request_in   = 1'b0;
               front_override_in = 1'b0;
            end else begin
               if (trigger_now) begin
                  if (!next_is_rear_ff) begin
                     rsp.fire_front  = 1'b1;
                     next_is_rear_in = rear_enabled_ff;
                  end else begin
                     rsp.fire_rear   = rear_allowed;
                     next_is_rear_in = 1'b0;
                  end
                  next_trigger_in = req.time_ms + {16'd0, gap_ff};
               end
               if (req.front_new) begin
                  if (front_positive) begin
                     stop_request_in = stop_set && (req.front_distance[14:0] < release_ff);
                  end else begin
                     stop_request_in = 1'b0;
                  end
               end
               rsp.safety_stop = stop_request_in && !front_override_ff;
               if (req.rear_new && rear_allowed) begin
                  rsp.rear_report_valid = 1'b1;
                  if (req.rear_distance[15]) begin
                     rsp.rear_report_timeout = 1'b1;
                  end else begin
                     rsp.rear_report_mm = req.rear_distance[14:0];
                  end
               end
            end
         end
         default: begin
            // unused code: drop the item, result stays zero
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_is_rear_ff   <= 1'b0;
         next_trigger_ff   <= FIRST_TRIGGER_MS;
         stop_request_ff   <= 1'b0;
         front_override_ff <= 1'b0;
         rear_enabled_ff   <= 1'b0;
         gap_ff            <= GAP_RESET;
         brake_ff          <= BRAKE_RESET;
         release_ff        <= RELEASE_RESET;
      end else begin
         if (step) begin
            next_is_rear_ff   <= next_is_rear_in;
            next_trigger_ff   <= next_trigger_in;
            stop_request_ff   <= stop_request_in;
            front_override_ff <= front_override_in;
            rear_enabled_ff   <= rear_enabled_in;
         end
         if (csr_we) begin
            unique case (csr.index)
               CSR_TRIGGER_GAP: gap_ff     <= csr.data;
               CSR_BRAKE:       brake_ff   <= csr.data[14:0];
               CSR_RELEASE:     release_ff <= csr.data[14:0];
               default: begin
                  // no register here: drop the write
               end
            endcase
         end
      end
   end

endmodule

// ===== rtl/uts_out_stage.sv =====
// ----------------------------------------------------------------------------
// Ultrasonic trigger scheduler result stage
// Register one result and hold it until the receiver takes it.
// ----------------------------------------------------------------------------
module uts_out_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   output logic             space,
   input  uts_pkg::rsp_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output uts_pkg::rsp_type out_data
);
   import uts_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   assign space    = !valid_ff || out_ready;
   assign valid_in = load || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         data_ff <= in_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== rtl/ultrasonic_trigger_scheduler_stop.sv =====
// ----------------------------------------------------------------------------
// Ultrasonic trigger scheduler with front stop request
// Top level: request register, scheduler engine and result register.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one tick or command transaction; rsp_* returns exactly one
//   result transaction for each, in order. csr_* writes the trigger gap, the
//   brake distance and the release distance; csr_ready is always high. Write
//   settings only while no transaction is in flight.
// Path: an accepted request waits in the request register, is evaluated by the
//   engine and is loaded into the result register, which drives rsp_valid;
//   the load waits while the result register is full.
// Throughput: one transaction per clock while rsp_ready keeps up; the bound
//   is the trigger time compare and hysteresis loop back into the state.
// Reset: state returns to front phase, first trigger at 200 ms, stop request,
//   override and rear enable clear, settings to 60 / 300 / 400; both pipeline
//   registers empty.
// Stall: with rsp_ready low the result register holds its transaction, the
//   request register takes one more, then req_ready drops until space frees.
// ----------------------------------------------------------------------------
module ultrasonic_trigger_scheduler_stop (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_action,
   input  logic               req_command_on,
   input  logic [31:0]        req_time_ms,
   input  logic [7:0]         req_mode_code,
   input  logic               req_front_busy,
   input  logic               req_rear_busy,
   input  logic               req_front_new,
   input  logic signed [15:0] req_front_distance,
   input  logic               req_rear_new,
   input  logic signed [15:0] req_rear_distance,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_fire_front,
   output logic               rsp_fire_rear,
   output logic               rsp_safety_stop,
   output logic               rsp_rear_report_valid,
   output logic               rsp_rear_report_timeout,
   output logic [14:0]        rsp_rear_report_mm,
   output logic               rsp_command_ack,
   // settings write channel
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata
);
   import uts_pkg::*;

   req_type req_in;
   req_type req_held;
   logic    held_valid;
   logic    out_space;
   logic    step;
   rsp_type rsp_next;
   rsp_type rsp_held;
   csr_type csr_wr;

   // Gather the request ports into one transaction.
   assign req_in.action         = req_action;
   assign req_in.command_on     = req_command_on;
   assign req_in.time_ms        = req_time_ms;
   assign req_in.mode_code      = req_mode_code;
   assign req_in.front_busy     = req_front_busy;
   assign req_in.rear_busy      = req_rear_busy;
   assign req_in.front_new      = req_front_new;
   assign req_in.front_distance = req_front_distance;
   assign req_in.rear_new       = req_rear_new;
   assign req_in.rear_distance  = req_rear_distance;

   assign csr_ready    = 1'b1;
   assign csr_wr.index = csr_index;
   assign csr_wr.data  = csr_wdata;

   // Advance the held request whenever the result register has room.
   assign step = held_valid && out_space;

   uts_in_stage u_in (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_in),
      .out_valid (held_valid),
      .out_take  (step),
      .out_data  (req_held)
   );

   uts_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .req    (req_held),
      .csr_we (csr_valid && csr_ready),
      .csr    (csr_wr),
      .rsp    (rsp_next)
   );

   uts_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (step),
      .space     (out_space),
      .in_data   (rsp_next),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_held)
   );

   // Spread the held result over the result ports.
   assign rsp_fire_front          = rsp_held.fire_front;
   assign rsp_fire_rear           = rsp_held.fire_rear;
   assign rsp_safety_stop         = rsp_held.safety_stop;
   assign rsp_rear_report_valid   = rsp_held.rear_report_valid;
   assign rsp_rear_report_timeout = rsp_held.rear_report_timeout;
   assign rsp_rear_report_mm      = rsp_held.rear_report_mm;
   assign rsp_command_ack         = rsp_held.command_ack;

endmodule

// ===== rtl/uts_checker.sv =====
// ----------------------------------------------------------------------------
// Ultrasonic trigger scheduler checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "ultrasonic_trigger_scheduler_stop_assert.svh"

module uts_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_fire_front,
   input logic        rsp_fire_rear,
   input logic        rsp_safety_stop,
   input logic        rsp_rear_report_valid,
   input logic        rsp_rear_report_timeout,
   input logic [14:0] rsp_rear_report_mm,
   input logic        rsp_command_ack
);

   logic [20:0] rsp_payload;
   logic        both_fired;
   logic        timeout_clean;
   logic        ack_quiet;

   assign rsp_payload   = {rsp_fire_front, rsp_fire_rear, rsp_safety_stop,
                           rsp_rear_report_valid, rsp_rear_report_timeout,
                           rsp_rear_report_mm, rsp_command_ack};
   assign both_fired    = rsp_fire_front && rsp_fire_rear;
   assign timeout_clean = rsp_rear_report_valid && (rsp_rear_report_mm == 15'd0);
   assign ack_quiet     = !rsp_fire_front && !rsp_fire_rear && !rsp_safety_stop
                          && !rsp_rear_report_valid;

   // A stalled result holds.
   `UTS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "result changed while stalled")

   // Only one sensor fires per transaction.
   `UTS_ASSERT_NOW(a_one_fire, clock, reset, rsp_valid, !both_fired, "both sensors fired")

   // A timeout report carries no distance.
   `UTS_ASSERT_NOW(a_timeout_report, clock, reset, rsp_valid && rsp_rear_report_timeout, timeout_clean, "bad timeout")

   // A command acknowledgement carries nothing else.
   `UTS_ASSERT_NOW(a_ack_alone, clock, reset, rsp_valid && rsp_command_ack, ack_quiet, "command result not clean")

endmodule

bind ultrasonic_trigger_scheduler_stop uts_checker u_uts_checker (.*);
